// File: src/wle_pkg.sv
// Shared constants and types of the waypoint list engine.
package wle_pkg;

  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_BEGIN   = 3'd2,
    OP_END     = 3'd3,
    OP_NEXT    = 3'd4,
    OP_GET_AT  = 3'd5,
    OP_GET_POI = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] alt;
    logic signed [15:0] heading;
    logic [7:0]         ptype;
    logic [7:0]         evt;
    logic [7:0]         hold;
    logic [7:0]         tol;
    logic [7:0]         status;
  } entry_t;

endpackage

// File: src/waypoint_list_engine_unit.sv
// Waypoint list engine top level: entry memory, operation sequencer and result register.
//
// Entries live in one synchronous memory of LIST_DEPTH rows with a single
// read port. Clear, append and unused codes go from the idle state straight to
// the done state; get_at and get_poi first pass a fetch state for one memory
// read. Begin, end and next scan the list one entry per cycle through the read
// port, up to LIST_DEPTH entries. One request is processed at a time; a new request
// is taken while the previous result still waits at the output register.
module waypoint_list_engine_unit import wle_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         wp_index_i,
  input  logic signed [31:0] latitude_i,
  input  logic signed [31:0] longitude_i,
  input  logic signed [31:0] altitude_i,
  input  logic [7:0]         pos_status_i,
  input  logic signed [15:0] heading_i,
  input  logic [7:0]         tolerance_radius_i,
  input  logic [7:0]         hold_time_i,
  input  logic [7:0]         marker_flag_i,
  input  logic [7:0]         point_type_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               found_o,
  output logic [7:0]         position_o,
  output logic [5:0]         count_o,
  output logic signed [31:0] out_latitude_o,
  output logic signed [31:0] out_longitude_o,
  output logic signed [31:0] out_altitude_o,
  output logic [7:0]         out_status_o,
  output logic signed [15:0] out_heading_o,
  output logic [7:0]         out_tolerance_o,
  output logic [7:0]         out_hold_time_o,
  output logic [7:0]         out_marker_flag_o,
  output logic [7:0]         out_type_o
);

  entry_t mem [LIST_DEPTH];

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cur_q, cur_d;
  logic [7:0]        poi_q, poi_d;
  logic [ADDR_W-1:0] scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0]  scan_left_q, scan_left_d;
  op_e               scan_op_q, scan_op_d;
  logic              pend_q, pend_d;
  logic [CNT_W-1:0]  pend_pos_q, pend_pos_d;
  entry_t            res_q, res_d;
  logic              res_found_q, res_found_d;
  logic [7:0]        res_pos_q, res_pos_d;
  logic              out_valid_q, out_valid_d;
  entry_t            out_q;
  logic              out_found_q;
  logic [7:0]        out_pos_q;
  logic [CNT_W-1:0]  out_count_q;

  entry_t            wdata;
  entry_t            rd_data_q;
  logic              mem_we;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        tgt;
  logic              hit;
  logic [7:0]        neg_hd;
  logic              out_ld;
  op_e               op;

  always_comb begin
    wdata.lat     = latitude_i;
    wdata.lon     = longitude_i;
    wdata.alt     = altitude_i;
    wdata.heading = heading_i;
    wdata.ptype   = point_type_i;
    wdata.evt     = marker_flag_i;
    wdata.hold    = hold_time_i;
    wdata.tol     = tolerance_radius_i;
    wdata.status  = pos_status_i;
  end

  assign op     = op_e'(operation_i);
  assign tgt    = (op == OP_GET_AT) ? wp_index_i : poi_q;
  assign hit    = pend_q && (rd_data_q.status != 8'd0) && (rd_data_q.ptype == 8'd0);
  assign neg_hd = 8'd0 - rd_data_q.heading[7:0];
  assign out_ld = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    poi_d       = poi_q;
    scan_idx_d  = scan_idx_q;
    scan_left_d = scan_left_q;
    scan_op_d   = scan_op_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;
    res_d       = res_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    mem_we      = 1'b0;
    rd_addr     = scan_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = ADDR_W'(tgt - 8'd1);
        if (in_valid_i) begin
          res_d       = '0;
          res_found_d = 1'b0;
          res_pos_d   = 8'd0;
          pend_d      = 1'b0;
          state_d     = ST_DONE;
          unique case (op) inside
            OP_CLEAR: begin
              count_d = '0;
              cur_d   = '0;
              poi_d   = 8'd0;
            end
            OP_APPEND: begin
              if (count_q < CNT_W'(LIST_DEPTH)) begin
                mem_we      = 1'b1;
                count_d     = count_q + CNT_W'(1);
                res_d       = wdata;
                res_found_d = 1'b1;
                res_pos_d   = 8'(count_d);
              end
            end
            OP_BEGIN, OP_END: begin
              if (count_q == '0) begin
                cur_d = '0;
                poi_d = 8'd0;
              end else begin
                scan_left_d = count_q;
                scan_op_d   = op;
                scan_idx_d  = (op == OP_BEGIN) ? '0 : ADDR_W'(count_q - CNT_W'(1));
                state_d     = ST_SCAN;
              end
            end
            OP_NEXT: begin
              if (cur_q < count_q) begin
                scan_left_d = count_q - cur_q;
                scan_op_d   = OP_NEXT;
                scan_idx_d  = ADDR_W'(cur_q);
                state_d     = ST_SCAN;
              end
            end
            OP_GET_AT, OP_GET_POI: begin
              if ((tgt != 8'd0) && (tgt <= 8'(count_q))) begin
                res_pos_d = tgt;
                state_d   = ST_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        res_d       = rd_data_q;
        res_found_d = 1'b1;
        state_d     = ST_DONE;
      end
      ST_SCAN: begin
        if (scan_left_q != '0) begin
          pend_d      = 1'b1;
          pend_pos_d  = CNT_W'(scan_idx_q) + CNT_W'(1);
          scan_left_d = scan_left_q - CNT_W'(1);
          scan_idx_d  = (scan_op_q == OP_END) ? scan_idx_q - ADDR_W'(1)
                                              : scan_idx_q + ADDR_W'(1);
        end
        if (hit) begin
          res_d       = rd_data_q;
          res_found_d = 1'b1;
          res_pos_d   = 8'(pend_pos_q);
          cur_d       = pend_pos_q;
          poi_d       = rd_data_q.heading[15] ? neg_hd : 8'd0;
          state_d     = ST_DONE;
        end else if (scan_left_q == '0) begin
          if (scan_op_q != OP_NEXT) begin
            cur_d = '0;
            poi_d = 8'd0;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_ld | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[ADDR_W'(count_q)] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      poi_q       <= 8'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      poi_q       <= poi_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q  <= scan_idx_d;
    scan_left_q <= scan_left_d;
    scan_op_q   <= scan_op_d;
    pend_pos_q  <= pend_pos_d;
    res_q       <= res_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    if (out_ld) begin
      out_q       <= res_q;
      out_found_q <= res_found_q;
      out_pos_q   <= res_pos_q;
      out_count_q <= count_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign found_o           = out_found_q;
  assign position_o        = out_pos_q;
  assign count_o           = 6'(out_count_q);
  assign out_latitude_o    = out_q.lat;
  assign out_longitude_o   = out_q.lon;
  assign out_altitude_o    = out_q.alt;
  assign out_status_o      = out_q.status;
  assign out_heading_o     = out_q.heading;
  assign out_tolerance_o   = out_q.tol;
  assign out_hold_time_o   = out_q.hold;
  assign out_marker_flag_o = out_q.evt;
  assign out_type_o        = out_q.ptype;

endmodule

// File: src/wle_checker.sv
// Port-level assertions for the waypoint list engine, bound to the top level.
module wle_checker import wle_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               found_o,
  input logic [7:0]         position_o,
  input logic [5:0]         count_o,
  input logic signed [31:0] out_latitude_o
);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o <= 6'(LIST_DEPTH)))
    else $error("count above list depth");

  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (position_o != 8'd0) && (position_o <= 8'(count_o)))
    else $error("found entry position outside list");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == 8'd0) && (out_latitude_o == 32'sd0))
    else $error("missed result not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(position_o) && $stable(count_o))
    else $error("stalled result changed");

endmodule

bind waypoint_list_engine_unit wle_checker u_wle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .position_o     (position_o),
  .count_o        (count_o),
  .out_latitude_o (out_latitude_o)
);
